FILE: hw/rtl/kbs_pkg.sv
// Package for the keyed byte scrambler: mode and register codes, key
// layout, transform constants and the configuration bundle. No dependencies.
package kbs_pkg;

    localparam int KEY_BYTES   = 32;
    localparam int POS_W       = $clog2(KEY_BYTES);
    localparam int KEY_WORDS   = KEY_BYTES / 8;
    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 6;

    // Fixed bit-inversion masks, one per position modulo 8 that uses one.
    localparam logic [7:0] MASK_POS0 = 8'hCF;
    localparam logic [7:0] MASK_POS1 = 8'hD8;
    localparam logic [7:0] MASK_POS3 = 8'h60;
    localparam logic [7:0] MASK_POS4 = 8'hF0;
    localparam logic [7:0] MASK_POS5 = 8'h87;
    localparam logic [7:0] MASK_POS6 = 8'hFF;

    // Add or subtract offset used at positions two and seven.
    localparam logic [7:0] KEY_OFFSET = 8'(KEY_BYTES);

    // User unmask mode constants.
    localparam logic [7:0] USER_MASK = 8'h78;
    localparam logic [7:0] USER_SUB  = 8'd14;

    typedef enum logic [1:0] {
        MODE_DECRYPT = 2'd0,
        MODE_ENCRYPT = 2'd1,
        MODE_USER    = 2'd2,
        MODE_BYPASS  = 2'd3
    } mode_t;

    // Register index, taken from byte address bits [5:3].
    typedef enum logic [2:0] {
        REG_MODE      = 3'd0,
        REG_KEY_WORD0 = 3'd1,
        REG_KEY_WORD1 = 3'd2,
        REG_KEY_WORD2 = 3'd3,
        REG_KEY_WORD3 = 3'd4
    } reg_idx_t;

    typedef logic [KEY_BYTES-1:0][7:0] key_t;
    typedef logic [POS_W-1:0]          pos_t;

    typedef struct packed {
        mode_t mode;
        key_t  key;
    } kbs_cfg_t;

endpackage

FILE: hw/rtl/kbs_stream_if.sv
// Valid/ready stream interfaces for the keyed byte scrambler input and
// result channels. Depends on kbs_pkg.
interface kbs_in_if;
    import kbs_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface kbs_out_if;
    import kbs_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] result_byte;

    modport source (output valid, output result_byte, input ready);
    modport sink   (input valid, input result_byte, output ready);
endinterface

FILE: hw/rtl/keyed_byte_scrambler.sv
// Keyed byte scrambler, top level. An accepted input transaction is captured in the
// input register and transformed, and its result is held in the output register,
// which drives the output channel.
// Throughput: one byte per cycle; the input register, the transform and the
// output register form a two-stage pipeline that stalls only on output ready.
// Reset (rst_n, asynchronous, active low) clears the pipeline valid flags,
// the stream position and all configuration registers.
module keyed_byte_scrambler (
    input  logic                                clk,
    input  logic                                rst_n,
    kbs_in_if.sink                              in_item,
    kbs_out_if.source                           out_item,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [kbs_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [kbs_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [kbs_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import kbs_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Each register sits at byte address 8*i, so
    // address bits [5:3] pick the register. Writes land on the access phase.
    // ------------------------------------------------------------------
    mode_t                          mode_reg;
    logic [KEY_WORDS-1:0][63:0]     key_word_reg;
    reg_idx_t                       reg_idx;
    logic                           cfg_write;
    kbs_cfg_t                       cfg;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[5:3]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_DECRYPT;
            key_word_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_MODE:      mode_reg        <= mode_t'(pwdata[1:0]);
                REG_KEY_WORD0: key_word_reg[0] <= pwdata;
                REG_KEY_WORD1: key_word_reg[1] <= pwdata;
                REG_KEY_WORD2: key_word_reg[2] <= pwdata;
                REG_KEY_WORD3: key_word_reg[3] <= pwdata;
                default:       ;
            endcase
        end
    end

    // Read-back; unused addresses read as zero.
    always_comb
    begin
        case (reg_idx)
            REG_MODE:      prdata = {{(APB_DATA_W-2){1'b0}}, mode_reg};
            REG_KEY_WORD0: prdata = key_word_reg[0];
            REG_KEY_WORD1: prdata = key_word_reg[1];
            REG_KEY_WORD2: prdata = key_word_reg[2];
            REG_KEY_WORD3: prdata = key_word_reg[3];
            default:       prdata = '0;
        endcase
    end

    // The key words pack straight into key bytes: byte 0 is the lowest byte
    // of word 0, byte 31 the highest byte of word 3.
    assign cfg.mode = mode_reg;
    assign cfg.key  = key_t'(key_word_reg);

    // ------------------------------------------------------------------
    // Stage one: input register. The stream position for each byte is
    // resolved here, as the transaction is taken, so that the position
    // counter advances exactly once per accepted byte. A restart forces
    // position zero for this byte and position one for the next.
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    pos_t       in_pos_reg;
    pos_t       stream_pos_reg;
    pos_t       item_pos;
    logic       in_take;
    logic       out_load_ok;
    logic       s1_advance;

    // The output register may load when it is empty or being emptied.
    assign out_load_ok = !out_item.valid || out_item.ready;
    assign s1_advance  = in_valid_reg && out_load_ok;

    // Stage one can take a new byte when empty or when its byte moves on.
    assign in_item.ready = !in_valid_reg || out_load_ok;
    assign in_take       = in_item.valid && in_item.ready;

    assign item_pos = in_item.restart ? '0 : stream_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            stream_pos_reg <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg   <= 1'b1;
                stream_pos_reg <= item_pos + 1'b1;
            end
            else if (s1_advance)
            begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= in_item.data_byte;
            in_pos_reg  <= item_pos;
        end
    end

    // ------------------------------------------------------------------
    // Transform between the two registers.
    // ------------------------------------------------------------------
    logic [7:0] result_next;

    kbs_transform u_transform (
        .cfg         (cfg),
        .pos         (in_pos_reg),
        .data_byte   (in_data_reg),
        .result_byte (result_next)
    );

    // ------------------------------------------------------------------
    // Stage two: output register, holding the result until the sink takes
    // the transaction.
    // ------------------------------------------------------------------
    logic       out_valid_reg;
    logic [7:0] result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load_ok)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_item.valid       = out_valid_reg;
    assign out_item.result_byte = result_reg;

endmodule

FILE: hw/rtl/kbs_transform.sv
// Byte transform of the keyed byte scrambler: key byte selection, the
// position-dependent inversion or offset, and the mode selection. Uses kbs_pkg.
module kbs_transform (
    input  kbs_pkg::kbs_cfg_t cfg,
    input  kbs_pkg::pos_t     pos,
    input  logic [7:0]        data_byte,
    output logic [7:0]        result_byte
);
    import kbs_pkg::*;

    logic [7:0] key_byte;
    logic [7:0] dec_in;
    logic [7:0] dec_out;
    logic [7:0] enc_in;
    logic [7:0] enc_out;

    assign key_byte = cfg.key[pos];

    // Decrypt direction: transform, then key.
    assign dec_in = data_byte;
    always_comb
    begin
        case (pos[2:0])
            3'd0:    dec_out = dec_in ^ MASK_POS0;
            3'd1:    dec_out = dec_in ^ MASK_POS1;
            3'd2:    dec_out = dec_in - KEY_OFFSET;
            3'd3:    dec_out = dec_in ^ MASK_POS3;
            3'd4:    dec_out = dec_in ^ MASK_POS4;
            3'd5:    dec_out = dec_in ^ MASK_POS5;
            3'd6:    dec_out = dec_in ^ MASK_POS6;
            default: dec_out = dec_in + KEY_OFFSET;
        endcase
    end

    // Encrypt direction: key, then the inverse transform.
    assign enc_in = data_byte ^ key_byte;
    always_comb
    begin
        case (pos[2:0])
            3'd0:    enc_out = enc_in ^ MASK_POS0;
            3'd1:    enc_out = enc_in ^ MASK_POS1;
            3'd2:    enc_out = enc_in + KEY_OFFSET;
            3'd3:    enc_out = enc_in ^ MASK_POS3;
            3'd4:    enc_out = enc_in ^ MASK_POS4;
            3'd5:    enc_out = enc_in ^ MASK_POS5;
            3'd6:    enc_out = enc_in ^ MASK_POS6;
            default: enc_out = enc_in - KEY_OFFSET;
        endcase
    end

    always_comb
    begin
        case (cfg.mode)
            MODE_DECRYPT: result_byte = dec_out ^ key_byte;
            MODE_ENCRYPT: result_byte = enc_out;
            MODE_USER:    result_byte = (data_byte ^ USER_MASK) - USER_SUB;
            default:      result_byte = data_byte;
        endcase
    end

endmodule
